>>> src/pclr_pkg.sv
package pclr_pkg;

   localparam int NUM_W = 14;
   localparam int ROW_W = 16;
   localparam int IDLE_W = 16;
   localparam int PROD_W = 18;

   localparam logic [7:0] ESC_BYTE = 8'h1B;
   localparam logic [7:0] LF_BYTE = 8'h0A;
   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_LO_R = 8'h72;
   localparam logic [7:0] CHAR_LO_B = 8'h62;
   localparam logic [7:0] CHAR_UP_A = 8'h41;
   localparam logic [7:0] CHAR_UP_B = 8'h42;
   localparam logic [7:0] CHAR_UP_W = 8'h57;
   localparam logic [7:0] CHAR_LO_FIRST = 8'h61;
   localparam logic [7:0] CHAR_LO_LAST = 8'h7A;
   localparam logic [7:0] CHAR_UP_FIRST = 8'h41;
   localparam logic [7:0] CHAR_UP_LAST = 8'h5A;
   localparam logic [7:0] CHAR_DIG_FIRST = 8'h30;
   localparam logic [7:0] CHAR_DIG_LAST = 8'h39;

   localparam logic [NUM_W-1:0] NUM_MAX = 14'd16383;
   localparam logic [ROW_W-1:0] ROW_MAX = 16'hFFFF;
   localparam logic [IDLE_W-1:0] IDLE_MAX = 16'hFFFF;
   localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 16'd500;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_PREFIX,
      PH_CMD,
      PH_NUM,
      PH_DATA
   } phase_type;

   typedef enum logic [1:0] {
      EV_BYTE,
      EV_START,
      EV_END,
      EV_ABORT
   } event_type;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      event_type        event_res;
      logic [ROW_W-1:0] row;
      logic [NUM_W-1:0] byte_column;
      logic [7:0]       pixels;
      logic [NUM_W-1:0] width_bytes;
      logic [ROW_W-1:0] height_rows;
   } rsp_type;

   typedef struct packed {
      phase_type         phase;
      logic [7:0]        prefix_char;
      logic [7:0]        command_char;
      logic [NUM_W-1:0]  number_value;
      logic [NUM_W-1:0]  bytes_left;
      logic [NUM_W-1:0]  column_index;
      logic [ROW_W-1:0]  row_count;
      logic [NUM_W-1:0]  max_width;
      logic              job_pending;
      logic [IDLE_W-1:0] idle_count;
   } state_type;

endpackage

>>> src/pclr_step.sv
module pclr_step #(
   parameter int MAX_DIGITS = 4,
   parameter int DigitW = $clog2(MAX_DIGITS + 1)
) (
   input  pclr_pkg::req_type             item,
   input  logic [pclr_pkg::IDLE_W-1:0]   timeout_ticks,
   input  pclr_pkg::state_type           cur,
   input  logic [DigitW-1:0]             cur_digits,
   output pclr_pkg::state_type           nxt,
   output logic [DigitW-1:0]             nxt_digits,
   output logic                          hit,
   output pclr_pkg::rsp_type             rsp
);

   logic [7:0] b;
   logic is_esc, is_lower, is_upper, is_digit;
   logic [pclr_pkg::PROD_W-1:0] prod;
   logic [pclr_pkg::IDLE_W-1:0] idle_inc;
   logic [pclr_pkg::NUM_W-1:0] left_dec;
   logic is_star_r;

   assign b = item.data_byte;
   assign is_esc = (b == pclr_pkg::ESC_BYTE);
   assign is_lower = (b >= pclr_pkg::CHAR_LO_FIRST) && (b <= pclr_pkg::CHAR_LO_LAST);
   assign is_upper = (b >= pclr_pkg::CHAR_UP_FIRST) && (b <= pclr_pkg::CHAR_UP_LAST);
   assign is_digit = (b >= pclr_pkg::CHAR_DIG_FIRST) && (b <= pclr_pkg::CHAR_DIG_LAST);
   // n*10 + digit; never above 18 bits since n is held below 16384
   assign prod = ({4'd0, cur.number_value} * pclr_pkg::PROD_W'(10))
               + pclr_pkg::PROD_W'(b - pclr_pkg::CHAR_DIG_FIRST);
   assign idle_inc = (cur.idle_count == pclr_pkg::IDLE_MAX) ? cur.idle_count
                                                             : cur.idle_count + 16'd1;
   assign left_dec = (cur.bytes_left != '0) ? cur.bytes_left - 14'd1 : cur.bytes_left;
   assign is_star_r = (cur.prefix_char == pclr_pkg::CHAR_STAR)
                   && (cur.command_char == pclr_pkg::CHAR_LO_R);

   always_comb begin
      nxt = cur;
      nxt_digits = cur_digits;
      hit = 1'b0;
      rsp = '0;
      if (item.command) begin
         // idle tick
         if (cur.job_pending) begin
            nxt.idle_count = idle_inc;
            if (idle_inc >= timeout_ticks) begin
               nxt.phase = pclr_pkg::PH_HUNT;
               nxt.prefix_char = '0;
               nxt.command_char = '0;
               nxt.number_value = '0;
               nxt_digits = '0;
               nxt.bytes_left = '0;
               nxt.column_index = '0;
               nxt.row_count = '0;
               nxt.job_pending = 1'b0;
               nxt.idle_count = '0;
               hit = 1'b1;
               rsp.event_res = pclr_pkg::EV_ABORT;
            end
         end
      end else begin
         nxt.idle_count = '0;
         nxt.job_pending = 1'b1;
         unique case (cur.phase)
            pclr_pkg::PH_DATA: begin
               hit = 1'b1;
               rsp.event_res = pclr_pkg::EV_BYTE;
               rsp.row = cur.row_count;
               rsp.byte_column = cur.column_index;
               rsp.pixels = b;
               nxt.column_index = cur.column_index + 14'd1;
               nxt.bytes_left = left_dec;
               if (left_dec == '0) begin
                  if (cur.row_count != pclr_pkg::ROW_MAX) begin
                     nxt.row_count = cur.row_count + 16'd1;
                  end
                  nxt.phase = pclr_pkg::PH_HUNT;
               end
            end
            pclr_pkg::PH_PREFIX: begin
               if (b == pclr_pkg::LF_BYTE) begin
                  nxt.prefix_char = '0;
                  nxt.command_char = '0;
                  nxt.number_value = '0;
                  nxt_digits = '0;
                  nxt.phase = pclr_pkg::PH_HUNT;
               end else begin
                  nxt.prefix_char = b;
                  nxt.phase = pclr_pkg::PH_CMD;
               end
            end
            pclr_pkg::PH_CMD: begin
               if (is_lower) begin
                  nxt.command_char = b;
                  nxt.number_value = '0;
                  nxt_digits = '0;
                  nxt.phase = pclr_pkg::PH_NUM;
               end else begin
                  nxt.prefix_char = '0;
                  nxt.command_char = '0;
                  nxt.number_value = '0;
                  nxt_digits = '0;
                  nxt.phase = is_esc ? pclr_pkg::PH_PREFIX : pclr_pkg::PH_HUNT;
               end
            end
            pclr_pkg::PH_NUM: begin
               if (is_digit && (cur_digits < DigitW'(MAX_DIGITS))) begin
                  nxt.number_value = (prod > pclr_pkg::PROD_W'(pclr_pkg::NUM_MAX))
                                   ? pclr_pkg::NUM_MAX : prod[pclr_pkg::NUM_W-1:0];
                  nxt_digits = cur_digits + DigitW'(1);
               end else begin
                  nxt.prefix_char = '0;
                  nxt.command_char = '0;
                  nxt.number_value = '0;
                  nxt_digits = '0;
                  if (is_upper) begin
                     // complete sequence
                     nxt.phase = pclr_pkg::PH_HUNT;
                     if (is_star_r && (b == pclr_pkg::CHAR_UP_A)) begin
                        hit = 1'b1;
                        rsp.event_res = pclr_pkg::EV_START;
                     end else if (is_star_r && (b == pclr_pkg::CHAR_UP_B)) begin
                        hit = 1'b1;
                        rsp.event_res = pclr_pkg::EV_END;
                        rsp.width_bytes = cur.max_width;
                        rsp.height_rows = cur.row_count;
                        nxt.row_count = '0;
                        nxt.job_pending = 1'b0;
                     end else if ((cur.prefix_char == pclr_pkg::CHAR_STAR)
                               && (cur.command_char == pclr_pkg::CHAR_LO_B)
                               && (b == pclr_pkg::CHAR_UP_W)) begin
                        if (cur.number_value > cur.max_width) begin
                           nxt.max_width = cur.number_value;
                        end
                        if (cur.number_value == '0) begin
                           if (cur.row_count != pclr_pkg::ROW_MAX) begin
                              nxt.row_count = cur.row_count + 16'd1;
                           end
                        end else begin
                           nxt.bytes_left = cur.number_value;
                           nxt.column_index = '0;
                           nxt.phase = pclr_pkg::PH_DATA;
                        end
                     end
                  end else begin
                     nxt.phase = is_esc ? pclr_pkg::PH_PREFIX : pclr_pkg::PH_HUNT;
                  end
               end
            end
            default: begin
               // hunting for ESC
               if (is_esc) begin
                  nxt.prefix_char = '0;
                  nxt.command_char = '0;
                  nxt.number_value = '0;
                  nxt_digits = '0;
                  nxt.phase = pclr_pkg::PH_PREFIX;
               end else begin
                  nxt.phase = pclr_pkg::PH_HUNT;
               end
            end
         endcase
      end
   end

endmodule

>>> src/pcl_raster_stream_parser.sv
// Channel   Direction  Handshake              Beat contents
// req_      in         req_valid/req_ready    pclr_pkg::req_type (command, data_byte)
// rsp_      out        rsp_valid/rsp_ready    pclr_pkg::rsp_type (event and raster fields)
// csr_      in         csr_valid/csr_ready    timeout_ticks, 16 bit
//
// One beat per cycle sustained while results are taken; a result reaches rsp_ through
// the input register, then the parse step into the result register, and is held
// there until taken.
// Throughput is set by the parser state registers, updated once per beat.
// Reset (synchronous, active high) returns the parser to hunting for ESC and the
// idle timeout to 500 ticks. A stalled result holds in its register while one
// more request waits in the input register; beats giving no result drain freely.
module pcl_raster_stream_parser #(
   parameter int MAX_DIGITS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pclr_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pclr_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pclr_pkg::IDLE_W-1:0]         csr_data
);

   localparam int DigitW = $clog2(MAX_DIGITS + 1);

   // input register
   logic                 in_valid_ff;
   pclr_pkg::req_type    in_data_ff;
   // parser state
   pclr_pkg::state_type  state_ff, state_in;
   logic [DigitW-1:0]    digits_ff, digits_in;
   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   pclr_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   // timeout setting
   logic [pclr_pkg::IDLE_W-1:0] timeout_ff;

   logic step_hit;
   logic advance;

   pclr_step #(
      .MAX_DIGITS (MAX_DIGITS),
      .DigitW     (DigitW)
   ) u_step (
      .item          (in_data_ff),
      .timeout_ticks (timeout_ff),
      .cur           (state_ff),
      .cur_digits    (digits_ff),
      .nxt           (state_in),
      .nxt_digits    (digits_in),
      .hit           (step_hit),
      .rsp           (rsp_data_in)
   );

   // the held beat moves on when its result has room, or it makes no result
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready || !step_hit);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && step_hit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff <= pclr_pkg::TIMEOUT_RESET;
         digits_ff <= '0;
         state_ff <= '{
            phase:        pclr_pkg::PH_HUNT,
            prefix_char:  '0,
            command_char: '0,
            number_value: '0,
            bytes_left:   '0,
            column_index: '0,
            row_count:    '0,
            max_width:    '0,
            job_pending:  1'b0,
            idle_count:   '0
         };
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
            digits_ff <= digits_in;
         end
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance && step_hit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> test/pcl_raster_stream_parser_tb.sv
module pcl_raster_stream_parser_tb;

   localparam int PARSE_DIGITS   = 4;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int PHASE_BEATS    = 240;

   typedef enum {ROW_BEAT, ROW_CSR} row_kind_type;

   // one line of the directed table: a request beat or a timeout write
   typedef struct {
      row_kind_type      kind;
      logic              cmd;
      logic [15:0]       value;
      bit                typed;
      pclr_pkg::rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                        req_valid;
   logic                        req_ready;
   pclr_pkg::req_type           req_data;
   logic                        rsp_valid;
   logic                        rsp_ready;
   pclr_pkg::rsp_type           rsp_data;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [pclr_pkg::IDLE_W-1:0] csr_data;

   // parser copy kept by the bench
   pclr_pkg::phase_type         scan_phase;
   logic [7:0]                  seq_prefix;
   logic [7:0]                  seq_cmd;
   logic [pclr_pkg::NUM_W-1:0]  seq_num;
   int                          seq_digits;
   logic [pclr_pkg::NUM_W-1:0]  line_left;
   logic [pclr_pkg::NUM_W-1:0]  line_col;
   logic [pclr_pkg::ROW_W-1:0]  row_total;
   logic [pclr_pkg::NUM_W-1:0]  width_peak;
   bit                          job_open;
   logic [pclr_pkg::IDLE_W-1:0] idle_ticks;
   logic [pclr_pkg::IDLE_W-1:0] timeout_reg;

   pclr_pkg::rsp_type event_q[$];
   stim_row_type      directed_rows[$];
   int        errors = 0;
   int        beats_done = 0;
   int        send_idle_pct = 0;
   int        rsp_stall_pct = 0;
   int        quiet_cycles = 0;

   pcl_raster_stream_parser #(
      .MAX_DIGITS(PARSE_DIGITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_seq_state();
      seq_prefix = '0;
      seq_cmd    = '0;
      seq_num    = '0;
      seq_digits = 0;
   endfunction

   // line finished: next row (saturating), back to the hunt
   function automatic void close_line();
      if (row_total != pclr_pkg::ROW_MAX) row_total++;
      scan_phase = pclr_pkg::PH_HUNT;
   endfunction

   // byte that breaks the pattern; ESC itself opens a fresh sequence
   function automatic void drop_seq(input logic [7:0] b);
      clear_seq_state();
      scan_phase = (b == pclr_pkg::ESC_BYTE) ? pclr_pkg::PH_PREFIX : pclr_pkg::PH_HUNT;
   endfunction

   function automatic pclr_pkg::rsp_type make_event(input pclr_pkg::event_type ev,
                                                    input int unsigned row,
                                                    input int unsigned col,
                                                    input int unsigned px,
                                                    input int unsigned w,
                                                    input int unsigned h);
      pclr_pkg::rsp_type e;
      e.event_res   = ev;
      e.row         = row[pclr_pkg::ROW_W-1:0];
      e.byte_column = col[pclr_pkg::NUM_W-1:0];
      e.pixels      = px[7:0];
      e.width_bytes = w[pclr_pkg::NUM_W-1:0];
      e.height_rows = h[pclr_pkg::ROW_W-1:0];
      return e;
   endfunction

   // Advances the parser copy by one accepted beat; returns 1 with the
   // expected result beat when the request gives one.
   function automatic bit parse_beat(input pclr_pkg::req_type beat,
                                     output pclr_pkg::rsp_type res);
      logic [7:0]                 b;
      logic [7:0]                 p;
      logic [7:0]                 c;
      logic [pclr_pkg::NUM_W-1:0] n;
      int unsigned                grown;
      bit                         got;
      b   = beat.data_byte;
      res = '0;
      got = 1'b0;
      if (beat.command) begin
         // idle tick: only counts while a job is open
         if (job_open) begin
            if (idle_ticks != pclr_pkg::IDLE_MAX) idle_ticks++;
            if (idle_ticks >= timeout_reg) begin
               scan_phase = pclr_pkg::PH_HUNT;
               clear_seq_state();
               line_left  = '0;
               line_col   = '0;
               row_total  = '0;
               job_open   = 1'b0;
               idle_ticks = '0;
               res.event_res = pclr_pkg::EV_ABORT;
               got = 1'b1;
            end
         end
      end else begin
         idle_ticks = '0;
         job_open   = 1'b1;
         case (scan_phase)
            pclr_pkg::PH_DATA: begin
               // raster data is consumed whole, escapes included
               res = make_event(pclr_pkg::EV_BYTE, row_total, line_col, b, 0, 0);
               got = 1'b1;
               line_col = line_col + 1'b1;
               if (line_left != 0) line_left--;
               if (line_left == 0) close_line();
            end
            pclr_pkg::PH_PREFIX: begin
               if (b == pclr_pkg::LF_BYTE) begin
                  drop_seq(b);
               end else begin
                  seq_prefix = b;
                  scan_phase = pclr_pkg::PH_CMD;
               end
            end
            pclr_pkg::PH_CMD: begin
               if (b >= pclr_pkg::CHAR_LO_FIRST && b <= pclr_pkg::CHAR_LO_LAST) begin
                  seq_cmd    = b;
                  seq_num    = '0;
                  seq_digits = 0;
                  scan_phase = pclr_pkg::PH_NUM;
               end else begin
                  drop_seq(b);
               end
            end
            pclr_pkg::PH_NUM: begin
               if (b >= pclr_pkg::CHAR_DIG_FIRST && b <= pclr_pkg::CHAR_DIG_LAST
                   && seq_digits < PARSE_DIGITS) begin
                  grown = seq_num * 10 + (b - pclr_pkg::CHAR_DIG_FIRST);
                  seq_num = (grown > pclr_pkg::NUM_MAX) ? pclr_pkg::NUM_MAX
                                                        : grown[pclr_pkg::NUM_W-1:0];
                  seq_digits++;
               end else if (b >= pclr_pkg::CHAR_UP_FIRST && b <= pclr_pkg::CHAR_UP_LAST) begin
                  // suffix closes the sequence
                  p = seq_prefix;
                  c = seq_cmd;
                  n = seq_num;
                  clear_seq_state();
                  scan_phase = pclr_pkg::PH_HUNT;
                  if (p == pclr_pkg::CHAR_STAR && c == pclr_pkg::CHAR_LO_R
                      && b == pclr_pkg::CHAR_UP_A) begin
                     res.event_res = pclr_pkg::EV_START;
                     got = 1'b1;
                  end else if (p == pclr_pkg::CHAR_STAR && c == pclr_pkg::CHAR_LO_R
                               && b == pclr_pkg::CHAR_UP_B) begin
                     res = make_event(pclr_pkg::EV_END, 0, 0, 0, width_peak, row_total);
                     got = 1'b1;
                     row_total  = '0;
                     job_open   = 1'b0;
                     idle_ticks = '0;
                  end else if (p == pclr_pkg::CHAR_STAR && c == pclr_pkg::CHAR_LO_B
                               && b == pclr_pkg::CHAR_UP_W) begin
                     if (n > width_peak) width_peak = n;
                     if (n == 0) begin
                        close_line();
                     end else begin
                        line_left  = n;
                        line_col   = '0;
                        scan_phase = pclr_pkg::PH_DATA;
                     end
                  end
               end else begin
                  drop_seq(b);
               end
            end
            default: begin
               if (b == pclr_pkg::ESC_BYTE) begin
                  clear_seq_state();
                  scan_phase = pclr_pkg::PH_PREFIX;
               end else begin
                  scan_phase = pclr_pkg::PH_HUNT;
               end
            end
         endcase
      end
      return got;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offers one request beat, holding it until taken, then predicts.
   task automatic send_item(input logic cmd, input logic [7:0] b);
      pclr_pkg::req_type beat;
      pclr_pkg::rsp_type res;
      beat.command   = cmd;
      beat.data_byte = b;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      // ticks with no open job leave the parser untouched
      if (!(cmd && !job_open)) beats_done++;
      if (parse_beat(beat, res)) event_q.push_back(res);
   endtask

   // Timeout write, only with the parser drained: all results in, then a settle
   // wait for beats that produce nothing.
   task automatic settle_and_write(input logic [pclr_pkg::IDLE_W-1:0] ticks);
      req_valid <= 1'b0;
      while (event_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= ticks;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      timeout_reg = ticks;
   endtask

   task automatic add_row(input row_kind_type kind, input logic cmd,
                          input logic [15:0] value, input bit typed,
                          input pclr_pkg::rsp_type want);
      stim_row_type r;
      r.kind  = kind;
      r.cmd   = cmd;
      r.value = value;
      r.typed = typed;
      r.want  = want;
      directed_rows.push_back(r);
   endtask

   // One random chunk of the byte stream. Mostly well-formed sequences with
   // random content, the rest broken sequences, stray bytes and tick bursts.
   task automatic gen_sequence();
      int          kind;
      int          n;
      int          nmin;
      int          ndig;
      int          tmp;
      int          i;
      int          k;
      int          digs[PARSE_DIGITS+1];
      logic [7:0]  v;
      kind = $urandom_range(99);
      if (kind < 15) begin
         send_item(1'b0, pclr_pkg::ESC_BYTE);
         send_item(1'b0, pclr_pkg::CHAR_STAR);
         send_item(1'b0, pclr_pkg::CHAR_LO_R);
         send_item(1'b0, pclr_pkg::CHAR_UP_A);
      end else if (kind < 25) begin
         send_item(1'b0, pclr_pkg::ESC_BYTE);
         send_item(1'b0, pclr_pkg::CHAR_STAR);
         send_item(1'b0, pclr_pkg::CHAR_LO_R);
         send_item(1'b0, pclr_pkg::CHAR_UP_B);
      end else if (kind < 60) begin
         // raster line, short mostly; leading zeros now and then
         n = ($urandom_range(19) == 0) ? $urandom_range(60, 11) : $urandom_range(10, 0);
         nmin = (n == 0) ? 0 : (n < 10) ? 1 : 2;
         ndig = $urandom_range(PARSE_DIGITS, nmin);
         tmp = n;
         for (i = 0; i < ndig; i++) begin
            digs[i] = tmp % 10;
            tmp = tmp / 10;
         end
         send_item(1'b0, pclr_pkg::ESC_BYTE);
         send_item(1'b0, pclr_pkg::CHAR_STAR);
         send_item(1'b0, pclr_pkg::CHAR_LO_B);
         for (i = ndig - 1; i >= 0; i--)
            send_item(1'b0, 8'(pclr_pkg::CHAR_DIG_FIRST + digs[i]));
         send_item(1'b0, pclr_pkg::CHAR_UP_W);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) send_item(1'b1, 8'($urandom_range(255)));
            send_item(1'b0, 8'($urandom_range(255)));
         end
      end else if (kind < 70) begin
         // some other complete sequence
         do v = 8'($urandom_range(255)); while (v == pclr_pkg::LF_BYTE);
         send_item(1'b0, pclr_pkg::ESC_BYTE);
         send_item(1'b0, $urandom_range(1) ? pclr_pkg::CHAR_STAR : v);
         send_item(1'b0, 8'(pclr_pkg::CHAR_LO_FIRST + $urandom_range(25)));
         ndig = $urandom_range(PARSE_DIGITS);
         for (i = 0; i < ndig; i++)
            send_item(1'b0, 8'(pclr_pkg::CHAR_DIG_FIRST + $urandom_range(9)));
         send_item(1'b0, 8'(pclr_pkg::CHAR_UP_FIRST + $urandom_range(25)));
      end else if (kind < 80) begin
         send_item(1'b0, pclr_pkg::ESC_BYTE);
         case ($urandom_range(3))
            0: send_item(1'b0, pclr_pkg::LF_BYTE);
            1: begin
               send_item(1'b0, pclr_pkg::CHAR_STAR);
               do v = 8'($urandom_range(255));
               while (v >= pclr_pkg::CHAR_LO_FIRST && v <= pclr_pkg::CHAR_LO_LAST);
               send_item(1'b0, v);
            end
            2: begin
               // one digit too many
               send_item(1'b0, pclr_pkg::CHAR_STAR);
               send_item(1'b0, pclr_pkg::CHAR_LO_B);
               for (i = 0; i <= PARSE_DIGITS; i++)
                  send_item(1'b0, 8'(pclr_pkg::CHAR_DIG_FIRST + $urandom_range(9)));
               send_item(1'b0, pclr_pkg::CHAR_UP_W);
            end
            default: begin
               send_item(1'b0, pclr_pkg::CHAR_STAR);
               send_item(1'b0, 8'(pclr_pkg::CHAR_LO_FIRST + $urandom_range(25)));
               ndig = $urandom_range(2);
               for (i = 0; i < ndig; i++)
                  send_item(1'b0, 8'(pclr_pkg::CHAR_DIG_FIRST + $urandom_range(9)));
               do v = 8'($urandom_range(255));
               while ((v >= pclr_pkg::CHAR_DIG_FIRST && v <= pclr_pkg::CHAR_DIG_LAST) ||
                      (v >= pclr_pkg::CHAR_UP_FIRST && v <= pclr_pkg::CHAR_UP_LAST));
               send_item(1'b0, v);
            end
         endcase
      end else if (kind < 90) begin
         k = $urandom_range(4, 1);
         for (i = 0; i < k; i++) send_item(1'b0, 8'($urandom_range(255)));
      end else begin
         k = $urandom_range(8, 1);
         for (i = 0; i < k; i++) send_item(1'b1, 8'($urandom_range(255)));
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Result beats are compared with the oldest expectation; the receiver's
   // ready is redrawn every cycle for the current stall rate.
   always @(posedge clock) begin
      pclr_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (event_q.size() == 0) begin
            $display("%0t unexpected result beat: expected none actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = event_q.pop_front();
            report_field("event_res", want.event_res, rsp_data.event_res);
            report_field("row", want.row, rsp_data.row);
            report_field("byte_column", want.byte_column, rsp_data.byte_column);
            report_field("pixels", want.pixels, rsp_data.pixels);
            report_field("width_bytes", want.width_bytes, rsp_data.width_bytes);
            report_field("height_rows", want.height_rows, rsp_data.height_rows);
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog: too long without any beat on any channel ends the run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int           p;
      int           i;
      logic [15:0]  t;
      stim_row_type r;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      rsp_ready <= 1'b1;

      scan_phase = pclr_pkg::PH_HUNT;
      clear_seq_state();
      line_left   = '0;
      line_col    = '0;
      row_total   = '0;
      width_peak  = '0;
      job_open    = 1'b0;
      idle_ticks  = '0;
      timeout_reg = pclr_pkg::TIMEOUT_RESET;

      // Directed table, reset timeout. Typed rows carry their result;
      // the rest go through the predictor.
      add_row(ROW_BEAT, 1'b1, 16'h00, 0, '0);  // tick, no job open
      add_row(ROW_BEAT, 1'b0, pclr_pkg::ESC_BYTE, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_STAR, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_LO_R, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_UP_A, 1,
              make_event(pclr_pkg::EV_START, 0, 0, 0, 0, 0));
      add_row(ROW_BEAT, 1'b0, pclr_pkg::ESC_BYTE, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_STAR, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_LO_B, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_DIG_FIRST + 8'd2, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_UP_W, 0, '0);
      add_row(ROW_BEAT, 1'b0, 16'hFF, 1, make_event(pclr_pkg::EV_BYTE, 0, 0, 8'hFF, 0, 0));
      add_row(ROW_BEAT, 1'b0, 16'h00, 1, make_event(pclr_pkg::EV_BYTE, 0, 1, 8'h00, 0, 0));
      // empty line still counts a row
      add_row(ROW_BEAT, 1'b0, pclr_pkg::ESC_BYTE, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_STAR, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_LO_B, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_UP_W, 0, '0);
      // line feed as prefix, then ESC breaking a command and restarting
      add_row(ROW_BEAT, 1'b0, pclr_pkg::ESC_BYTE, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::LF_BYTE, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::ESC_BYTE, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_STAR, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::ESC_BYTE, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_STAR, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_LO_R, 0, '0);
      add_row(ROW_BEAT, 1'b0, pclr_pkg::CHAR_UP_B, 1,
              make_event(pclr_pkg::EV_END, 0, 0, 0, 2, 2));
      // zero timeout: first tick of an open job aborts it
      add_row(ROW_CSR, 1'b0, 16'h0000, 0, '0);
      add_row(ROW_BEAT, 1'b0, 16'h78, 0, '0);
      add_row(ROW_BEAT, 1'b1, 16'h00, 1, make_event(pclr_pkg::EV_ABORT, 0, 0, 0, 0, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++) begin
         r = directed_rows[i];
         if (r.kind == ROW_CSR) begin
            settle_and_write(r.value);
         end else begin
            send_item(r.cmd, r.value[7:0]);
            // typed rows stand in for the prediction just queued
            if (r.typed) event_q[$] = r.want;
         end
      end

      // Random phases: timeout setting and idling pattern change together.
      for (p = 0; p < 8; p++) begin
         case (p)
            0:       t = 16'd1;
            1:       t = 16'hFFFF;
            2:       t = 16'd3;
            3:       t = 16'($urandom_range(40, 1));
            4:       t = pclr_pkg::TIMEOUT_RESET;
            5:       t = 16'd2;
            6:       t = 16'($urandom_range(16'hFFFF, 1));
            default: t = 16'd7;
         endcase
         settle_and_write(t);
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 65; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 65; end
            default: begin send_idle_pct = 9; rsp_stall_pct = 9; end
         endcase
         if (p == 7) begin
            // widest announced line, cut short by the timeout, then an end
            // beat reporting that width
            send_item(1'b0, pclr_pkg::ESC_BYTE);
            send_item(1'b0, pclr_pkg::CHAR_STAR);
            send_item(1'b0, pclr_pkg::CHAR_LO_B);
            for (i = 0; i < PARSE_DIGITS; i++) send_item(1'b0, pclr_pkg::CHAR_DIG_LAST);
            send_item(1'b0, pclr_pkg::CHAR_UP_W);
            for (i = 0; i < 3; i++) send_item(1'b0, 8'($urandom_range(255)));
            for (i = 0; i < timeout_reg; i++) send_item(1'b1, 8'($urandom_range(255)));
            send_item(1'b0, pclr_pkg::ESC_BYTE);
            send_item(1'b0, pclr_pkg::CHAR_STAR);
            send_item(1'b0, pclr_pkg::CHAR_LO_R);
            send_item(1'b0, pclr_pkg::CHAR_UP_B);
         end
         i = beats_done + PHASE_BEATS;
         while (beats_done < i) gen_sequence();
      end

      req_valid <= 1'b0;
      while (event_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
